// ===== design/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every design file.
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic        [1:0]  action;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } spq_cmd_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [4:0]  removed_count;
        logic               entry_valid;
        logic signed [31:0] entry_value;
        logic signed [31:0] entry_priority;
        logic               last_result;
    } spq_result_t;

    // one stored list entry
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } spq_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_RD,
        S_DEL_CMP,
        S_DUMP
    } spq_state_t;

endpackage

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue top level: command decode, list sequencer, result register.
// Depends on spq_pkg and spq_ram.
//
// A command is taken when start is high and busy is low. Each result shows on result
// for one cycle with done high; the receiver cannot stall, so it must take every result
// as it comes. The list lives in a RAM with one read port and registered read data,
// and that port sets the timing. The cycle that shows the final result is also the
// first cycle in which a new command can be taken. An insert walks back from the tail,
// reading the entry above the hole, then moving it down one place or writing the new
// entry into the hole, or dropping it straight in once the hole is at the head; a delete
// compacts the list in place, reading each stored entry and keeping it only if its value
// does not match; a dump streams one entry per cycle once its first read returns. A full
// insert, an empty dump and an unused action code answer the next cycle.
// Busy stays high until the final result is on its way.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  spq_pkg::spq_cmd_t    cmd,
    output logic                 done,
    output spq_pkg::spq_result_t result
);
    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    spq_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic          rvalid_reg, rvalid_next;
    logic          rlast_reg, rlast_next;
    spq_cmd_t      cmd_reg, cmd_next;
    logic          done_reg, done_next;
    spq_result_t   result_reg, result_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    spq_entry_t    mem_wdata;
    logic [AW-1:0] mem_raddr;
    spq_entry_t    mem_rdata;

    logic [CW-1:0] idx_dec;
    logic [CW-1:0] removed;
    logic [CW+4:0] removed_ext;
    spq_entry_t    new_entry;

    spq_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign idx_dec     = idx_reg - CW'(1);
    assign removed     = count_reg - wr_reg;
    assign removed_ext = {5'b0, removed};
    assign new_entry   = '{value: cmd_reg.item_value, prio: cmd_reg.item_priority};

    // sequencer: next state, memory controls and result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        wr_next     = wr_reg;
        rvalid_next = 1'b0;
        rlast_next  = 1'b0;
        cmd_next    = cmd_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_dec[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    result_next = '0;
                    result_next.last_result = 1'b1;
                    unique case (cmd.action)
                        ACT_INSERT:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                result_next.status = ST_FULL;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        ACT_DELETE:
                        begin
                            idx_next   = '0;
                            wr_next    = '0;
                            state_next = S_DEL_RD;
                        end
                        ACT_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                // read the entry above the hole, or drop the new entry at the head
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = new_entry;
                    count_next = count_reg + CW'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                // equal or higher priority stays ahead of the new entry
                mem_we = 1'b1;
                if (mem_rdata.prio >= cmd_reg.item_priority)
                begin
                    mem_wdata  = new_entry;
                    count_next = count_reg + CW'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end
            end
            S_DEL_RD:
            begin
                mem_raddr = idx_reg[AW-1:0];
                if (idx_reg == count_reg)
                begin
                    count_next = wr_reg;
                    result_next.removed_count = removed_ext[4:0];
                    result_next.status = (removed == '0) ? ST_NOT_FOUND : ST_DONE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DEL_CMP;
                end
            end
            S_DEL_CMP:
            begin
                // keep non-matching entries, packed toward the head
                mem_waddr = wr_reg[AW-1:0];
                if (mem_rdata.value != cmd_reg.item_value)
                begin
                    mem_we  = 1'b1;
                    wr_next = wr_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_DEL_RD;
            end
            S_DUMP:
            begin
                // issue one read per cycle; the returned RAM data is registered into the result
                mem_raddr = idx_reg[AW-1:0];
                if (idx_reg != count_reg)
                begin
                    rvalid_next = 1'b1;
                    rlast_next  = (idx_reg == count_reg - CW'(1));
                    idx_next    = idx_reg + CW'(1);
                end
                if (rvalid_reg)
                begin
                    result_next = '0;
                    result_next.entry_valid    = 1'b1;
                    result_next.entry_value    = mem_rdata.value;
                    result_next.entry_priority = mem_rdata.prio;
                    result_next.last_result    = rlast_reg;
                    done_next                  = 1'b1;
                    if (rlast_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            wr_reg     <= '0;
            rvalid_reg <= 1'b0;
            rlast_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            wr_reg     <= wr_next;
            rvalid_reg <= rvalid_next;
            rlast_reg  <= rlast_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/spq_ram.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on spq_pkg for the entry type.
module spq_ram #(
    parameter int DEPTH = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  spq_pkg::spq_entry_t        wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output spq_pkg::spq_entry_t        rdata
);
    import spq_pkg::*;

    spq_entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg for the result type and status codes.
module spq_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input spq_pkg::spq_cmd_t    cmd,
    input logic                 done,
    input spq_pkg::spq_result_t result
);
    import spq_pkg::*;

    // an accepted command either starts work or answers at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither went busy nor answered");

    // a dump stream has no gaps until its last entry
    a_stream_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last_result) |=> done)
        else $error("dump stream broke before its last entry");

    // results before the last one keep the block busy
    a_busy_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last_result) |-> busy)
        else $error("block idle while a dump is still streaming");

    // dumped entries carry no status and no removal count
    a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.entry_valid) |->
            (result.status == ST_DONE && result.removed_count == 5'd0))
        else $error("dumped entry with status or removal count set");

    // a rejected insert is a single answer with nothing removed
    a_full_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |->
            (result.last_result && result.removed_count == 5'd0 && !result.entry_valid))
        else $error("malformed list-full answer");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for sorted_priority_queue: directed table then random commands.
// Depends on spq_pkg and the sorted_priority_queue RTL; a behavioral list model predicts
// every result, which is checked field by field as results stream out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int          LIST_DEPTH   = DEFAULT_CAPACITY;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam int          RANDOM_ITEMS = 135;
    localparam int          DRAIN_CYCLES = 2 * LIST_DEPTH + 20;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MAX_REPORTS  = 10;

    typedef struct {
        spq_cmd_t    cmd;
        bit          typed;
        spq_result_t reply;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    spq_cmd_t    cmd;
    logic        done;
    spq_result_t result;

    // list model state
    logic signed [31:0] list_values [LIST_DEPTH];
    logic signed [31:0] list_prios  [LIST_DEPTH];
    int                 list_count;

    spq_result_t expected_replies[$];
    stim_row_t   stim_table[$];

    int fail_count;
    int cycle_count;
    int no_idle_left;
    int n_insert_ok, n_full, n_delete_hit, n_not_found, n_dumps, n_dumped, n_unused;
    int peak_count;
    int n_checked;

    spq_result_t got_reply, want_reply;
    string       bad_fields;

    sorted_priority_queue #(
        .CAPACITY(LIST_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .result(result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic spq_result_t mk_result(logic [1:0] st, logic [4:0] rc, logic ev,
                                              logic signed [31:0] v, logic signed [31:0] p,
                                              logic lr);
        spq_result_t r;
        r.status         = st;
        r.removed_count  = rc;
        r.entry_valid    = ev;
        r.entry_value    = v;
        r.entry_priority = p;
        r.last_result    = lr;
        return r;
    endfunction

    // list behavior: update the model and queue the results one command causes
    task automatic apply_command(input spq_cmd_t c);
        logic signed [31:0] v;
        logic signed [31:0] p;
        int                 pos;
        int                 wr;
        v = c.item_value;
        p = c.item_priority;
        case (c.action)
            ACT_INSERT:
            begin
                if (list_count >= LIST_DEPTH)
                begin
                    n_full++;
                    expected_replies.push_back(mk_result(ST_FULL, 5'd0, 1'b0, 0, 0, 1'b1));
                end
                else
                begin
                    // new entry goes after every entry of equal or higher priority
                    pos = 0;
                    while (pos < list_count && list_prios[pos] >= p)
                        pos++;
                    for (int i = list_count; i > pos; i--)
                    begin
                        list_values[i] = list_values[i - 1];
                        list_prios[i]  = list_prios[i - 1];
                    end
                    list_values[pos] = v;
                    list_prios[pos]  = p;
                    list_count++;
                    if (list_count > peak_count)
                        peak_count = list_count;
                    n_insert_ok++;
                    expected_replies.push_back(mk_result(ST_DONE, 5'd0, 1'b0, 0, 0, 1'b1));
                end
            end
            ACT_DELETE:
            begin
                // compact the list, dropping every matching value
                wr = 0;
                for (int rd = 0; rd < list_count; rd++)
                begin
                    if (list_values[rd] != v)
                    begin
                        list_values[wr] = list_values[rd];
                        list_prios[wr]  = list_prios[rd];
                        wr++;
                    end
                end
                if (wr == list_count)
                begin
                    n_not_found++;
                    expected_replies.push_back(mk_result(ST_NOT_FOUND, 5'd0, 1'b0, 0, 0, 1'b1));
                end
                else
                begin
                    n_delete_hit++;
                    expected_replies.push_back(mk_result(ST_DONE, 5'(list_count - wr), 1'b0,
                                                         0, 0, 1'b1));
                end
                list_count = wr;
            end
            ACT_DUMP:
            begin
                n_dumps++;
                if (list_count == 0)
                    expected_replies.push_back(mk_result(ST_DONE, 5'd0, 1'b0, 0, 0, 1'b1));
                for (int i = 0; i < list_count; i++)
                begin
                    n_dumped++;
                    expected_replies.push_back(mk_result(ST_DONE, 5'd0, 1'b1, list_values[i],
                                                         list_prios[i], i == list_count - 1));
                end
            end
            default:
            begin
                n_unused++;
                expected_replies.push_back(mk_result(ST_DONE, 5'd0, 1'b0, 0, 0, 1'b1));
            end
        endcase
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // one command transfer, then the sender's idle gap before the next one
    task automatic issue(input spq_cmd_t c, input bit typed, input spq_result_t reply);
        int gap;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_command(c);
        // hand-typed expectation replaces the model's single result
        if (typed)
            expected_replies[expected_replies.size() - 1] = reply;
        if (no_idle_left > 0)
        begin
            no_idle_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 15) == 0)
                no_idle_left = $urandom_range(5, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender holds off until every outstanding result has come back
    task automatic pause_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() > 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [1:0] act, input logic signed [31:0] v,
                           input logic signed [31:0] p, input bit typed,
                           input spq_result_t reply);
        stim_row_t row;
        row.cmd.action        = act;
        row.cmd.item_value    = v;
        row.cmd.item_priority = p;
        row.typed             = typed;
        row.reply             = reply;
        stim_table.push_back(row);
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 32'($urandom_range(0, 8)) - 32'sd4;
        else if (r < 9)
            return $urandom;
        else
            return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    function automatic logic signed [31:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 32'($urandom_range(0, 4)) - 32'sd2;
        else if (r < 9)
            return $urandom;
        else
            return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    function automatic spq_cmd_t random_command();
        spq_cmd_t c;
        int       r;
        r = $urandom_range(0, 99);
        c.item_value    = pick_value();
        c.item_priority = $urandom;
        if (r < 55)
        begin
            c.action        = ACT_INSERT;
            c.item_priority = pick_priority();
        end
        else if (r < 75)
        begin
            c.action = ACT_DELETE;
            // mostly aim at a value that is held so deletes find something
            if (list_count > 0 && $urandom_range(0, 2) != 0)
                c.item_value = list_values[$urandom_range(0, list_count - 1)];
        end
        else if (r < 95)
            c.action = ACT_DUMP;
        else
            c.action = ACT_UNUSED;
        return c;
    endfunction

    // result checker: every strobed result is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            got_reply = result;
            if (expected_replies.size() == 0)
                note_failure($sformatf("unexpected result st=%0d rc=%0d ev=%0d val=%0d pri=%0d last=%0d",
                                       got_reply.status, got_reply.removed_count,
                                       got_reply.entry_valid, got_reply.entry_value,
                                       got_reply.entry_priority, got_reply.last_result));
            else
            begin
                want_reply = expected_replies.pop_front();
                n_checked++;
                bad_fields = "";
                if (got_reply.status !== want_reply.status)
                    bad_fields = {bad_fields, " status"};
                if (got_reply.removed_count !== want_reply.removed_count)
                    bad_fields = {bad_fields, " removed_count"};
                if (got_reply.entry_valid !== want_reply.entry_valid)
                    bad_fields = {bad_fields, " entry_valid"};
                if (got_reply.entry_value !== want_reply.entry_value)
                    bad_fields = {bad_fields, " entry_value"};
                if (got_reply.entry_priority !== want_reply.entry_priority)
                    bad_fields = {bad_fields, " entry_priority"};
                if (got_reply.last_result !== want_reply.last_result)
                    bad_fields = {bad_fields, " last_result"};
                if (bad_fields != "")
                    note_failure($sformatf({"mismatch in%s at %0t: expected st=%0d rc=%0d ev=%0d ",
                                            "val=%0d pri=%0d last=%0d, got st=%0d rc=%0d ev=%0d ",
                                            "val=%0d pri=%0d last=%0d"},
                                           bad_fields, $realtime,
                                           want_reply.status, want_reply.removed_count,
                                           want_reply.entry_valid, want_reply.entry_value,
                                           want_reply.entry_priority, want_reply.last_result,
                                           got_reply.status, got_reply.removed_count,
                                           got_reply.entry_valid, got_reply.entry_value,
                                           got_reply.entry_priority, got_reply.last_result));
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL sorted_priority_queue");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int               sent;
        bit               paused_once;
        spq_cmd_t         c;
        logic signed [31:0] fill_prios [16];

        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        list_count   = 0;
        fail_count   = 0;
        cycle_count  = 0;
        no_idle_left = 0;
        n_insert_ok  = 0;
        n_full       = 0;
        n_delete_hit = 0;
        n_not_found  = 0;
        n_dumps      = 0;
        n_dumped     = 0;
        n_unused     = 0;
        peak_count   = 0;
        n_checked    = 0;
        sent         = 0;
        paused_once  = 1'b0;

        fill_prios = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh7fffffff, 32'sh80000000,
                       5, 5, -5, 0, 32'sh40000000, 32'shc0000000, 1, -1, 0};

        // directed rows: empty list, unused code, extremes, fifo ties, fill to full
        add_row(ACT_DUMP, 0, 0, 1'b1, mk_result(ST_DONE, 5'd0, 1'b0, 0, 0, 1'b1));
        add_row(ACT_DELETE, 5, 0, 1'b1, mk_result(ST_NOT_FOUND, 5'd0, 1'b0, 0, 0, 1'b1));
        add_row(ACT_UNUSED, -1, -1, 1'b1, mk_result(ST_DONE, 5'd0, 1'b0, 0, 0, 1'b1));
        add_row(ACT_INSERT, 32'sh7fffffff, 0, 1'b1,
                mk_result(ST_DONE, 5'd0, 1'b0, 0, 0, 1'b1));
        add_row(ACT_INSERT, 32'sh80000000, 0, 1'b1,
                mk_result(ST_DONE, 5'd0, 1'b0, 0, 0, 1'b1));
        add_row(ACT_DUMP, 0, 0, 1'b0, '0);
        add_row(ACT_DELETE, 32'sh7fffffff, 0, 1'b1,
                mk_result(ST_DONE, 5'd1, 1'b0, 0, 0, 1'b1));
        add_row(ACT_DELETE, 32'sh80000000, 0, 1'b1,
                mk_result(ST_DONE, 5'd1, 1'b0, 0, 0, 1'b1));
        for (int i = 0; i < LIST_DEPTH; i++)
            add_row(ACT_INSERT, -7, fill_prios[i % 16], 1'b0, '0);
        add_row(ACT_INSERT, 9, 32'sh7fffffff, 1'b1, mk_result(ST_FULL, 5'd0, 1'b0, 0, 0, 1'b1));
        add_row(ACT_DUMP, 0, 0, 1'b0, '0);
        add_row(ACT_DELETE, -7, 0, 1'b1,
                mk_result(ST_DONE, 5'(LIST_DEPTH), 1'b0, 0, 0, 1'b1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            issue(stim_table[i].cmd, stim_table[i].typed, stim_table[i].reply);

        // random part: mostly single commands, now and then a fill-to-full sequence
        while (sent < RANDOM_ITEMS)
        begin
            if ((!paused_once && sent >= 60) || $urandom_range(0, 39) == 0)
            begin
                pause_until_drained();
                paused_once = 1'b1;
            end
            if ($urandom_range(0, 24) == 0)
            begin
                while (list_count <= LIST_DEPTH && sent < RANDOM_ITEMS)
                begin
                    c.action        = ACT_INSERT;
                    c.item_value    = pick_value();
                    c.item_priority = pick_priority();
                    if (list_count == LIST_DEPTH)
                        list_count = list_count;
                    issue(c, 1'b0, '0);
                    sent++;
                    if (n_full > 0 && list_count == LIST_DEPTH && $urandom_range(0, 1) == 0)
                        break;
                end
                c.action = ACT_DUMP;
                issue(c, 1'b0, '0);
                sent++;
            end
            else
            begin
                issue(random_command(), 1'b0, '0);
                sent++;
            end
        end

        start <= 1'b0;
        while (expected_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d inserts (%0d refused on a full list), %0d deletes with hits, %0d without",
                 n_insert_ok, n_full, n_delete_hit, n_not_found);
        $display("%0d dumps streaming %0d entries, %0d unused codes, peak fill %0d, %0d results checked",
                 n_dumps, n_dumped, n_unused, peak_count, n_checked);
        if (fail_count == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end

endmodule

// ===== sorted_priority_queue.f =====
design/spq_pkg.sv
design/spq_ram.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
sim/tb.sv
